>>> hdl/uip_pkg.sv
// Shared types, widths and character codes of the unsigned integer text parser.
package uip_pkg;

    // Width of the saturating consumed-character counter.
    localparam int COUNT_BITS = 16;
    localparam int VALUE_BITS = 64;
    localparam int CHARS_BITS = 16;
    localparam int CHAR_BITS = 8;
    localparam int RADIX_BITS = 5;
    localparam int S_DATA_BITS = 16;
    localparam int M_DATA_BITS = 80;

    // Character codes and bases the parser tests against.
    localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_BITS-1:0] CHAR_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_LF    = 8'h66;
    localparam logic [CHAR_BITS-1:0] CHAR_LX    = 8'h78;

    localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 5'd0;
    localparam logic [RADIX_BITS-1:0] RADIX_OCT  = 5'd8;
    localparam logic [RADIX_BITS-1:0] RADIX_DEC  = 5'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_HEX  = 5'd16;

    // One input item as held in the input register.
    typedef struct packed {
        logic [CHAR_BITS-1:0]  char_code;
        logic                  begin_string;
        logic [RADIX_BITS-1:0] radix;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [VALUE_BITS-1:0] parsed_value;
        logic [CHARS_BITS-1:0] chars_consumed;
    } result_t;

endpackage

>>> hdl/uip_in_stage.sv
// Input register stage of the unsigned integer text parser.
module uip_in_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [uip_pkg::S_DATA_BITS-1:0]   s_tdata,
    input  logic                              s_tuser,
    input  logic                              take,
    output logic                              item_valid,
    output uip_pkg::item_t                    item
);

    logic           valid_reg;
    uip_pkg::item_t item_reg;

    // The register may refill whenever it is empty or its item moves on.
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag and payload of the held item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.char_code    <= s_tdata[uip_pkg::CHAR_BITS-1:0];
            item_reg.radix        <= s_tdata[uip_pkg::CHAR_BITS +: uip_pkg::RADIX_BITS];
            item_reg.begin_string <= s_tuser;
        end
    end

endmodule

>>> hdl/uip_parse_core.sv
// Parse state and combinational next-state logic of the unsigned integer text parser.
module uip_parse_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  uip_pkg::item_t      item,
    output logic                emit,
    output uip_pkg::result_t    result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    phase_t                               phase_reg, phase_next;
    logic                                 minus_reg, minus_next;
    logic [uip_pkg::VALUE_BITS-1:0]       acc_reg, acc_next;
    logic [uip_pkg::RADIX_BITS-1:0]       radix_reg, radix_next;
    logic [uip_pkg::COUNT_BITS-1:0]       count_reg, count_next;

    phase_t                               cur_phase;
    logic                                 cur_minus;
    logic [uip_pkg::VALUE_BITS-1:0]       cur_acc;
    logic [uip_pkg::RADIX_BITS-1:0]       cur_radix;
    logic [uip_pkg::COUNT_BITS-1:0]       cur_count;
    logic [uip_pkg::COUNT_BITS-1:0]       count_inc;

    logic [uip_pkg::CHAR_BITS-1:0]        c;
    logic                                 is_digit;
    logic [3:0]                           digit;
    logic                                 take;
    logic [uip_pkg::RADIX_BITS-1:0]       rad_use;
    logic [uip_pkg::VALUE_BITS-1:0]       acc_mul;

    assign c = item.char_code;

    // A start mark resets the parse before the character is looked at.
    always_comb begin
        if (item.begin_string) begin
            cur_phase = PH_LEAD;
            cur_minus = 1'b0;
            cur_acc   = '0;
            cur_radix = item.radix;
            cur_count = '0;
        end else begin
            cur_phase = phase_reg;
            cur_minus = minus_reg;
            cur_acc   = acc_reg;
            cur_radix = radix_reg;
            cur_count = count_reg;
        end
    end

    // Saturating increment of the consumed-character count.
    assign count_inc = (&cur_count) ? cur_count : cur_count + 1'b1;

    // Digit value of the character.
    always_comb begin
        is_digit = 1'b0;
        digit    = '0;
        if (c >= uip_pkg::CHAR_ZERO && c <= uip_pkg::CHAR_NINE) begin
            is_digit = 1'b1;
            digit    = 4'(c - uip_pkg::CHAR_ZERO);
        end else if (c >= uip_pkg::CHAR_LA && c <= uip_pkg::CHAR_LF) begin
            is_digit = 1'b1;
            digit    = 4'(c - uip_pkg::CHAR_LA + 8'd10);
        end else if (c >= uip_pkg::CHAR_UA && c <= uip_pkg::CHAR_UF) begin
            is_digit = 1'b1;
            digit    = 4'(c - uip_pkg::CHAR_UA + 8'd10);
        end
    end

    // Phase decisions; a digit attempt is resolved in the common block below.
    always_comb begin
        phase_next = cur_phase;
        minus_next = cur_minus;
        acc_next   = cur_acc;
        radix_next = cur_radix;
        count_next = cur_count;
        take       = 1'b0;
        rad_use    = cur_radix;
        emit       = 1'b0;
        acc_mul    = '0;
        case (cur_phase)
            PH_IDLE: begin
            end
            PH_LEAD, PH_SIGNED: begin
                if (cur_phase == PH_LEAD &&
                        (c == uip_pkg::CHAR_SPACE || c == uip_pkg::CHAR_TAB)) begin
                    count_next = count_inc;
                end else if (cur_phase == PH_LEAD &&
                        (c == uip_pkg::CHAR_MINUS || c == uip_pkg::CHAR_PLUS)) begin
                    minus_next = (c == uip_pkg::CHAR_MINUS);
                    count_next = count_inc;
                    phase_next = PH_SIGNED;
                end else if ((cur_radix == uip_pkg::RADIX_AUTO ||
                        cur_radix == uip_pkg::RADIX_HEX) && c == uip_pkg::CHAR_ZERO) begin
                    count_next = count_inc;
                    phase_next = PH_ZERO;
                end else begin
                    take    = 1'b1;
                    rad_use = (cur_radix == uip_pkg::RADIX_AUTO) ?
                              uip_pkg::RADIX_DEC : cur_radix;
                end
            end
            PH_ZERO: begin
                if (c == uip_pkg::CHAR_LX || c == uip_pkg::CHAR_UX) begin
                    radix_next = uip_pkg::RADIX_HEX;
                    count_next = count_inc;
                    phase_next = PH_DIGITS;
                end else begin
                    take    = 1'b1;
                    rad_use = (cur_radix == uip_pkg::RADIX_AUTO) ?
                              uip_pkg::RADIX_OCT : cur_radix;
                end
            end
            PH_DIGITS: begin
                take = 1'b1;
            end
            default: begin
            end
        endcase

        // Accumulator times base as a shift-add over the five base bits.
        for (int i = 0; i < uip_pkg::RADIX_BITS; i++) begin
            if (rad_use[i]) begin
                acc_mul = acc_mul + (cur_acc << i);
            end
        end

        // Accept a digit below the base, otherwise stop and give the result.
        if (take) begin
            radix_next = rad_use;
            if (!is_digit || 5'(digit) >= rad_use) begin
                emit       = 1'b1;
                phase_next = PH_IDLE;
            end else begin
                acc_next   = acc_mul + 64'(digit);
                count_next = count_inc;
                phase_next = PH_DIGITS;
            end
        end
    end

    // Result payload, built from the state before the stopping character.
    assign result.parsed_value   = cur_minus ? (64'd0 - cur_acc) : cur_acc;
    assign result.chars_consumed = uip_pkg::CHARS_BITS'(cur_count);

    // Parse state, updated once for every item that moves through.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            minus_reg <= 1'b0;
            acc_reg   <= '0;
            radix_reg <= '0;
            count_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            minus_reg <= minus_next;
            acc_reg   <= acc_next;
            radix_reg <= radix_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> hdl/uip_out_stage.sv
// Result register stage of the unsigned integer text parser.
module uip_out_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  uip_pkg::result_t                  result,
    output logic                              free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [uip_pkg::M_DATA_BITS-1:0]   m_tdata
);

    logic             valid_reg;
    uip_pkg::result_t result_reg;

    // The register can take a new result when empty or being drained.
    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {result_reg.chars_consumed, result_reg.parsed_value};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

>>> hdl/unsigned_integer_text_parser.sv
// A character is held in the input register, its result in the result register.
// Throughput: one character per cycle while the result register has room; the loop is
// the parse state through the shift-add base multiply.
// A waiting result holds the parser only when the result register stays full.
// Reset: synchronous active-low aresetn clears the valid flags and sets the parse idle.
module unsigned_integer_text_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: char_code[7:0], radix[12:8], zero fill[15:13].
    input  logic [uip_pkg::S_DATA_BITS-1:0]   s_tdata,
    // Fields from bit 0: begin_string.
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: parsed_value[63:0], chars_consumed[79:64].
    output logic [uip_pkg::M_DATA_BITS-1:0]   m_tdata
);

    logic             item_valid;
    uip_pkg::item_t   item;
    logic             out_free;
    logic             step;
    logic             emit;
    uip_pkg::result_t result;

    // An item advances when the result register has room for whatever it gives.
    assign step = item_valid && out_free;

    uip_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    uip_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .emit    (emit),
        .result  (result)
    );

    uip_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && emit),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> tb/sv/testbench.sv
// Testbench for the unsigned integer text parser: scoreboard, stream drivers and stimulus.
module testbench;
    import uip_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } parse_phase_t;

    // Tracks the parse of the character stream and holds the results still owed by the block.
    class parse_scoreboard;
        parse_phase_t         phase;
        bit                   minus;
        logic [VALUE_BITS-1:0] acc;
        logic [RADIX_BITS-1:0] base;
        longint unsigned      count;
        result_t              expected_q[$];
        int                   errors;

        function new();
            phase = PH_IDLE;
            minus = 1'b0;
            acc = '0;
            base = RADIX_AUTO;
            count = 0;
            errors = 0;
        endfunction

        // Counts one consumed character, holding at the counter's maximum.
        function void bump();
            if (count < (64'd1 << COUNT_BITS) - 1) begin
                count++;
            end
        endfunction

        // Takes a digit below the base, or stops the parse and owes a result.
        function void take_digit(logic [CHAR_BITS-1:0] c);
            int unsigned d;
            result_t     r;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                d = c - CHAR_ZERO;
            end else if (c >= CHAR_LA && c <= CHAR_LF) begin
                d = c - CHAR_LA + 10;
            end else if (c >= CHAR_UA && c <= CHAR_UF) begin
                d = c - CHAR_UA + 10;
            end else begin
                d = 255;
            end
            if (d == 255 || d >= base) begin
                r.parsed_value = minus ? -acc : acc;
                r.chars_consumed = count[CHARS_BITS-1:0];
                expected_q.push_back(r);
                phase = PH_IDLE;
            end else begin
                acc = acc * VALUE_BITS'(base) + VALUE_BITS'(d);
                bump();
                phase = PH_DIGITS;
            end
        endfunction

        // First character after the blanks and the sign: a zero may open a prefix.
        function void first_of_number(logic [CHAR_BITS-1:0] c);
            if ((base == RADIX_AUTO || base == RADIX_HEX) && c == CHAR_ZERO) begin
                bump();
                phase = PH_ZERO;
            end else begin
                if (base == RADIX_AUTO) begin
                    base = RADIX_DEC;
                end
                take_digit(c);
            end
        endfunction

        // Notes one accepted item; returns 0 when the block ignores it.
        function bit note_char(logic [CHAR_BITS-1:0] c, bit first, logic [RADIX_BITS-1:0] rdx);
            if (first) begin
                phase = PH_LEAD;
                minus = 1'b0;
                acc = '0;
                base = rdx;
                count = 0;
            end
            if (phase == PH_IDLE) begin
                return 1'b0;
            end
            case (phase)
                PH_LEAD: begin
                    if (c == CHAR_SPACE || c == CHAR_TAB) begin
                        bump();
                    end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
                        minus = (c == CHAR_MINUS);
                        bump();
                        phase = PH_SIGNED;
                    end else begin
                        first_of_number(c);
                    end
                end
                PH_SIGNED: begin
                    first_of_number(c);
                end
                PH_ZERO: begin
                    if (c == CHAR_LX || c == CHAR_UX) begin
                        base = RADIX_HEX;
                        bump();
                        phase = PH_DIGITS;
                    end else begin
                        if (base == RADIX_AUTO) begin
                            base = RADIX_OCT;
                        end
                        take_digit(c);
                    end
                end
                default: begin
                    take_digit(c);
                end
            endcase
            return 1'b1;
        endfunction

        // Compares one result item with the oldest owed result.
        function void check_result(logic [M_DATA_BITS-1:0] data);
            result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected result: parsed_value %h chars_consumed %0d",
                       data[VALUE_BITS-1:0], data[VALUE_BITS +: CHARS_BITS]);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (data[VALUE_BITS-1:0] !== exp_r.parsed_value) begin
                $error("parsed_value expected %h actual %h",
                       exp_r.parsed_value, data[VALUE_BITS-1:0]);
                errors++;
            end
            if (data[VALUE_BITS +: CHARS_BITS] !== exp_r.chars_consumed) begin
                $error("chars_consumed expected %0d actual %0d",
                       exp_r.chars_consumed, data[VALUE_BITS +: CHARS_BITS]);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // Fields from bit 0: char_code[7:0], radix[12:8], zero fill[15:13].
    logic [S_DATA_BITS-1:0] s_tdata = '0;
    // Fields from bit 0: begin_string.
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // Fields from bit 0: parsed_value[63:0], chars_consumed[79:64].
    logic [M_DATA_BITS-1:0] m_tdata;

    parse_scoreboard sb = new();
    logic [CHAR_BITS-1:0] text_q[$];
    bit sender_burst = 1'b0;
    bit sink_burst = 1'b0;
    int items_taken = 0;

    unsigned_integer_text_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Offers one item after a random gap and waits until it is accepted.
    task automatic send_char(logic [CHAR_BITS-1:0] c, bit first, logic [RADIX_BITS-1:0] rdx);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, rdx, c};
        s_tuser <= first;
        do @(posedge aclk); while (!s_tready);
        if (sb.note_char(c, first, rdx)) begin
            items_taken++;
        end
    endtask

    // Sends the held text as one string, the first character carrying the start mark.
    task automatic send_text(logic [RADIX_BITS-1:0] rdx);
        foreach (text_q[i]) begin
            send_char(text_q[i], i == 0, rdx);
        end
    endtask

    function automatic void load(string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endfunction

    // Holds the sender off until every owed result has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    // Result side: random back-pressure with stretches of none.
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                sink_burst = !sink_burst;
            end
            gap = sink_burst ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    // Ends the run when nothing moves on either side for too long.
    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("unsigned_integer_text_parser verification failed");
        $finish;
    end

    initial begin
        logic [RADIX_BITS-1:0] rdx;
        logic [CHAR_BITS-1:0]  c;
        int unsigned           base;
        int unsigned           d;
        int unsigned           n;
        int                    strings;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed strings: ignored input, prefixes, odd bases, restart, no digits.
        send_char("Z", 1'b0, RADIX_AUTO);
        load("0xg");
        send_text(RADIX_AUTO);
        load("017");
        text_q.push_back(CHAR_NUL);
        send_text(RADIX_AUTO);
        load("01");
        send_text(5'd1);
        load("fF");
        text_q.push_back(CHAR_NUL);
        send_text(5'd31);
        load("+7");
        send_text(RADIX_DEC);
        load("\t-");
        text_q.push_back(8'hFF);
        send_text(RADIX_AUTO);
        load("0");
        text_q.push_back(CHAR_NUL);
        send_text(RADIX_HEX);
        load(" 0X1F");
        text_q.push_back(CHAR_NUL);
        send_text(RADIX_HEX);
        load("-1");
        text_q.push_back(CHAR_NUL);
        send_text(RADIX_DEC);
        wait_drained();

        // Random strings: mostly well formed with random content, some noise.
        strings = 0;
        while (items_taken < RANDOM_ITEMS) begin
            strings++;
            if (strings % 20 == 0) begin
                wait_drained();
            end
            sender_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) == 0) begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    send_char(CHAR_BITS'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)),
                              RADIX_BITS'($urandom_range(0, 31)));
                end
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: rdx = RADIX_AUTO;
                    3, 4:    rdx = RADIX_DEC;
                    5, 6:    rdx = RADIX_HEX;
                    7:       rdx = RADIX_OCT;
                    default: rdx = RADIX_BITS'($urandom_range(0, 31));
                endcase
                text_q.delete();
                n = $urandom_range(0, 3);
                repeat (n) begin
                    text_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
                end
                case ($urandom_range(0, 2))
                    1: text_q.push_back(CHAR_PLUS);
                    2: text_q.push_back(CHAR_MINUS);
                    default: ;
                endcase
                if ((rdx == RADIX_AUTO || rdx == RADIX_HEX) &&
                        $urandom_range(0, 2) == 0) begin
                    text_q.push_back(CHAR_ZERO);
                    text_q.push_back($urandom_range(0, 1) ? CHAR_LX : CHAR_UX);
                    base = 16;
                end else if (rdx == RADIX_AUTO && $urandom_range(0, 2) == 0) begin
                    text_q.push_back(CHAR_ZERO);
                    base = 8;
                end else begin
                    base = (rdx == RADIX_AUTO) ? 10 : rdx;
                end
                // Long digit runs push the accumulator past 64 bits.
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) :
                                                  $urandom_range(0, 12);
                repeat (n) begin
                    d = (base <= 1) ? 0 : $urandom_range(0, (base > 16 ? 16 : base) - 1);
                    if (d < 10) begin
                        c = CHAR_BITS'(CHAR_ZERO + d);
                    end else begin
                        c = CHAR_BITS'(($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + d - 10);
                    end
                    if ($urandom_range(0, 29) == 0) begin
                        c = CHAR_BITS'($urandom_range(0, 255));
                    end
                    text_q.push_back(c);
                end
                // Stop on the terminator, on a random character, or not at all.
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: text_q.push_back(CHAR_NUL);
                    5, 6:          text_q.push_back(CHAR_BITS'($urandom_range(0, 255)));
                    7, 8:          ;
                    default: begin
                        text_q.push_back(CHAR_NUL);
                        n = $urandom_range(1, 3);
                        repeat (n) text_q.push_back(CHAR_BITS'($urandom_range(0, 255)));
                    end
                endcase
                send_text(rdx);
            end
        end

        // Drain and let the pipeline settle before the verdict.
        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("unsigned_integer_text_parser verification clean");
        end else begin
            $display("unsigned_integer_text_parser verification failed");
        end
        $finish;
    end

endmodule
